/* src/round_robin_slot_allocator_core_assert.svh */
// Assertion macros shared by the checkers of the slot allocator.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ROUND_ROBIN_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define ROUND_ROBIN_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// A condition that must hold at every sampled edge.
`define RRSA_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that, once true, implies another one in the same cycle.
`define RRSA_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that, once true, implies another one in the next cycle.
`define RRSA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rrsa_pkg.sv */
package rrsa_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned SLOT_IDX_W   = 4;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned FREE_CNT_W   = 5;
  localparam int unsigned WAIT_CNT_W   = 4;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned CFG_DATA_W   = 5;

  // Smallest pool the allocator runs with.
  localparam int unsigned MIN_SLOTS    = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_SLOT_COUNT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCKING_MODE = 2'd1;

  // Request commands. The unused code behaves as a status query.
  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_STATUS  = 2'd2
  } cmd_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_RELEASED    = 3'd3,
    ST_HANDED_OFF  = 3'd4,
    ST_REL_IGNORED = 3'd5,
    ST_STATUS      = 3'd6
  } status_e;

endpackage

/* src/rrsa_if.sv */
// Request channel: one command per handshake.
interface rrsa_req_if
  import rrsa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [SLOT_IDX_W-1:0] release_index;

  modport source (output valid, output cmd, output release_index, input ready);
  modport sink   (input valid, input cmd, input release_index, output ready);
endinterface

// Response channel: one response per request.
interface rrsa_rsp_if
  import rrsa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  grant_valid;
  logic [SLOT_IDX_W-1:0] grant_index;
  logic                  all_free;
  logic [FREE_CNT_W-1:0] free_count;
  logic [WAIT_CNT_W-1:0] waiting_count;

  modport source (output valid, output status, output grant_valid, output grant_index,
                  output all_free, output free_count, output waiting_count, input ready);
  modport sink   (input valid, input status, input grant_valid, input grant_index,
                  input all_free, input free_count, input waiting_count, output ready);
endinterface

// Configuration write channel.
interface rrsa_cfg_if
  import rrsa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

/* src/round_robin_slot_allocator_core.sv */
// Channel  | Modport      | Moves
// ---------+--------------+---------------------------------------------
// req_i    | sink         | request: cmd, release_index
// rsp_o    | source       | response: status, grant, all_free, counts
// cfg_i    | sink         | register write: addr, wdata (always ready)
//
// One request per cycle is sustained while the response is taken; each request passes
// from acceptance to response through an input register and a response register.
// The search, the state update and the counts are worked out between the two registers.
// Reset clears the pool: no slot in use, pointer and waiters at zero, three slots.
// A stalled response holds its register; the input register still takes one more request.
// A write to the slot count or blocking mode register clears the pool.
module round_robin_slot_allocator_core
  import rrsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS   = 16,
  parameter int unsigned MAX_WAITERS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rrsa_req_if.sink   req_i,
  rrsa_rsp_if.source rsp_o,
  rrsa_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW  = $clog2(MAX_SLOTS);
  localparam int unsigned CntW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned WaitW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned CmpW  = (CntW > CFG_DATA_W) ? CntW : CFG_DATA_W;

  // Configuration and pool state.
  logic [CntW-1:0]      slot_count_q;
  logic                 blocking_q;
  logic [MAX_SLOTS-1:0] in_use_q, in_use_d;
  logic [IdxW-1:0]      start_q, start_d;
  logic [WaitW-1:0]     waiters_q, waiters_d;
  logic [CntW-1:0]      used_q, used_d;

  // Input register.
  logic                  in_vld_q;
  logic [CMD_W-1:0]      in_cmd_q;
  logic [SLOT_IDX_W-1:0] in_rel_q;

  // Response register.
  logic                  out_vld_q;
  status_e               out_status_q, out_status_d;
  logic                  out_gvalid_q, out_gvalid_d;
  logic [SLOT_IDX_W-1:0] out_gidx_q, out_gidx_d;
  logic                  out_all_free_q;
  logic [FREE_CNT_W-1:0] out_free_q;
  logic [WAIT_CNT_W-1:0] out_wait_q;

  logic                 advance;
  logic                 cfg_write;
  logic [MAX_SLOTS-1:0] live_mask;
  logic [MAX_SLOTS-1:0] free_mask;
  logic                 pick_found;
  logic [IdxW-1:0]      pick_index;
  logic                 rel_in_range;
  logic [IdxW-1:0]      rel_index;
  logic [CmpW-1:0]      cfg_value;
  logic [CntW-1:0]      cfg_slots;

  // Handshakes: the input register refills whenever its request moves on.
  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid &&
                       ((cfg_i.addr == REG_SLOT_COUNT) || (cfg_i.addr == REG_BLOCKING_MODE));

  // Clamp a slot count write into the supported range.
  always_comb begin
    cfg_value = CmpW'(cfg_i.wdata);
    if (cfg_value < CmpW'(MIN_SLOTS)) begin
      cfg_slots = CntW'(MIN_SLOTS);
    end else if (cfg_value > CmpW'(MAX_SLOTS)) begin
      cfg_slots = CntW'(MAX_SLOTS);
    end else begin
      cfg_slots = CntW'(cfg_value);
    end
  end

  // Slots below the configured count are live.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      live_mask[i] = (CntW'(i) < slot_count_q);
    end
  end

  assign free_mask = live_mask & ~in_use_q;

  rrsa_pick #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_pick (
    .free_i (free_mask),
    .start_i(start_q),
    .found_o(pick_found),
    .index_o(pick_index)
  );

  assign rel_in_range = CmpW'(in_rel_q) < CmpW'(slot_count_q);
  assign rel_index    = IdxW'(in_rel_q);

  // Pointer one past a slot, wrapping at the configured count.
  function automatic logic [IdxW-1:0] next_start(logic [IdxW-1:0] idx,
                                                 logic [CntW-1:0] count);
    logic [CntW-1:0] inc;
    inc = CntW'(idx) + CntW'(1);
    return (inc == count) ? '0 : IdxW'(inc);
  endfunction

  // Command decode and next pool state.
  always_comb begin
    in_use_d     = in_use_q;
    start_d      = start_q;
    waiters_d    = waiters_q;
    used_d       = used_q;
    out_status_d = ST_STATUS;
    out_gvalid_d = 1'b0;
    out_gidx_d   = '0;
    case (in_cmd_q)
      CMD_ACQUIRE: begin
        if (pick_found) begin
          in_use_d[pick_index] = 1'b1;
          start_d              = next_start(pick_index, slot_count_q);
          used_d               = used_q + CntW'(1);
          out_status_d         = ST_GRANTED;
          out_gvalid_d         = 1'b1;
          out_gidx_d           = SLOT_IDX_W'(pick_index);
        end else if (blocking_q && (waiters_q < WaitW'(MAX_WAITERS))) begin
          waiters_d    = waiters_q + WaitW'(1);
          out_status_d = ST_QUEUED;
        end else begin
          out_status_d = ST_NO_FREE;
        end
      end
      CMD_RELEASE: begin
        if (!rel_in_range) begin
          out_status_d = ST_REL_IGNORED;
        end else if (waiters_q != '0) begin
          // The slot goes straight to a waiter and is marked in use.
          waiters_d           = waiters_q - WaitW'(1);
          in_use_d[rel_index] = 1'b1;
          if (!in_use_q[rel_index]) begin
            used_d = used_q + CntW'(1);
          end
          start_d      = next_start(rel_index, slot_count_q);
          out_status_d = ST_HANDED_OFF;
          out_gvalid_d = 1'b1;
          out_gidx_d   = in_rel_q;
        end else begin
          in_use_d[rel_index] = 1'b0;
          if (in_use_q[rel_index]) begin
            used_d = used_q - CntW'(1);
          end
          out_status_d = ST_RELEASED;
        end
      end
      default: begin
        out_status_d = ST_STATUS;
      end
    endcase
  end

  // Configuration registers and pool state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= CntW'(MIN_SLOTS);
      blocking_q   <= 1'b0;
      in_use_q     <= '0;
      start_q      <= '0;
      waiters_q    <= '0;
      used_q       <= '0;
    end else if (cfg_write) begin
      if (cfg_i.addr == REG_SLOT_COUNT) begin
        slot_count_q <= cfg_slots;
      end else begin
        blocking_q <= cfg_i.wdata[0];
      end
      in_use_q  <= '0;
      start_q   <= '0;
      waiters_q <= '0;
      used_q    <= '0;
    end else if (advance) begin
      in_use_q  <= in_use_d;
      start_q   <= start_d;
      waiters_q <= waiters_d;
      used_q    <= used_d;
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_cmd_q <= req_i.cmd;
      in_rel_q <= req_i.release_index;
    end
  end

  // Response register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Response register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q   <= out_status_d;
      out_gvalid_q   <= out_gvalid_d;
      out_gidx_q     <= out_gidx_d;
      out_all_free_q <= (used_d == '0);
      out_free_q     <= FREE_CNT_W'(slot_count_q - used_d);
      out_wait_q     <= WAIT_CNT_W'(waiters_d);
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.grant_valid   = out_gvalid_q;
  assign rsp_o.grant_index   = out_gidx_q;
  assign rsp_o.all_free      = out_all_free_q;
  assign rsp_o.free_count    = out_free_q;
  assign rsp_o.waiting_count = out_wait_q;

endmodule

/* src/rrsa_pick.sv */
// Round-robin search: finds the first free slot at or after the start
// pointer, wrapping to the lowest free slot below it.
module rrsa_pick
  import rrsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 16
) (
  input  logic [MAX_SLOTS-1:0]         free_i,
  input  logic [$clog2(MAX_SLOTS)-1:0] start_i,
  output logic                         found_o,
  output logic [$clog2(MAX_SLOTS)-1:0] index_o
);

  localparam int unsigned IdxW = $clog2(MAX_SLOTS);

  logic [MAX_SLOTS-1:0] upper;
  logic                 hi_found;
  logic                 lo_found;
  logic [IdxW-1:0]      hi_index;
  logic [IdxW-1:0]      lo_index;

  // Free slots at or above the start pointer.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      upper[i] = free_i[i] && (IdxW'(i) >= start_i);
    end
  end

  // Lowest set bit of each candidate mask; scanning down lets the lowest win.
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_index = '0;
    lo_index = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (upper[i]) begin
        hi_found = 1'b1;
        hi_index = IdxW'(i);
      end
      if (free_i[i]) begin
        lo_found = 1'b1;
        lo_index = IdxW'(i);
      end
    end
  end

  // Prefer the slot past the pointer, otherwise wrap around.
  assign found_o = lo_found;
  assign index_o = hi_found ? hi_index : lo_index;

endmodule

/* src/rrsa_checker.sv */
// Port-level checks on the response channel of the slot allocator.
module rrsa_checker
  import rrsa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic [STATUS_W-1:0]   status_i,
  input logic                  grant_valid_i,
  input logic [SLOT_IDX_W-1:0] grant_index_i,
  input logic [FREE_CNT_W-1:0] free_count_i,
  input logic [WAIT_CNT_W-1:0] waiting_count_i
);

`include "round_robin_slot_allocator_core_assert.svh"

  // A grant is flagged exactly for a new grant or a hand-off to a waiter.
  `RRSA_ASSERT_IMPLY(a_grant_matches_status, rsp_valid_i, grant_valid_i == ((status_i == ST_GRANTED) || (status_i == ST_HANDED_OFF)), "grant_valid disagrees with status")

  // Without a grant the slot index reads as zero.
  `RRSA_ASSERT_IMPLY(a_no_grant_zero_index, rsp_valid_i && !grant_valid_i, grant_index_i == '0, "grant_index set without a grant")

  // Acquires only queue while the pool is exhausted.
  `RRSA_ASSERT_IMPLY(a_waiters_only_when_full, rsp_valid_i && (waiting_count_i != '0), free_count_i == '0, "waiters present while slots are free")

  // A stalled response keeps its contents.
  `RRSA_ASSERT_NEXT(a_stall_holds, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable({status_i, grant_valid_i, grant_index_i, free_count_i, waiting_count_i}), "response changed while stalled")

endmodule

bind round_robin_slot_allocator_core rrsa_checker u_rrsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .grant_valid_i  (rsp_o.grant_valid),
  .grant_index_i  (rsp_o.grant_index),
  .free_count_i   (rsp_o.free_count),
  .waiting_count_i(rsp_o.waiting_count)
);
